FILE: design/oal_pkg.sv
// shared constants, opcodes and state codes for the ordered array list engine
`default_nettype none

package oal_pkg;

  localparam int Capacity = 16;
  localparam int FieldW   = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int WordW    = 2 * FieldW;
  localparam int OpW      = 3;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_AT    = 3'd4,
    OP_REM_BACK  = 3'd5,
    OP_FIND_DATA = 3'd6,
    OP_FIND_KEY  = 3'd7
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INS  = 4'b0010,
    ST_REM  = 4'b0100,
    ST_FIND = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: design/oal_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module oal_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/ordered_array_list_engine.sv
// top level of the ordered array list engine: sequencer around one entry ram
//
// Usage: drive opcode_i, position_i, entry_key_i and entry_data_i and raise
// start_i; the item is taken at a rising edge where start_i is high and busy_o
// is low. Exactly one result follows per item: done_o is high for one cycle
// with success_o, result_key_o, result_data_o, entry_count_o, is_empty_o and
// is_full_o. The receiver cannot stall; the result must be taken that cycle.
// Key and data pairs live in one ram with a registered read; the sequencer
// moves about one entry per cycle through its single read and single write
// port, so timing follows the number of entries touched:
//   rejected item (full, empty, bad position): done_o the cycle after accept
//   insert at a: entries from the top down to a move up, then a is written
//   remove at a: entry a is read out, the entries above it move down
//   find: reads from index 0 up to the first match, or every entry on a miss
// busy_o is low again in the cycle that shows done_o, so a new item may be
// started there.
// Reset empties the list (count zero) and clears the sequencer; ram contents
// are not cleared since only entries below the count are ever read.
`default_nettype none

module ordered_array_list_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [oal_pkg::OpW-1:0]     opcode_i,
  input  wire logic [oal_pkg::IdxW-1:0]    position_i,
  input  wire logic [oal_pkg::FieldW-1:0]  entry_key_i,
  input  wire logic [oal_pkg::FieldW-1:0]  entry_data_i,
  output logic                             done_o,
  output logic                             success_o,
  output logic      [oal_pkg::FieldW-1:0]  result_key_o,
  output logic      [oal_pkg::FieldW-1:0]  result_data_o,
  output logic      [oal_pkg::CntW-1:0]    entry_count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  oal_pkg::state_e               state_q, state_d;
  oal_pkg::opcode_e              op_q, op_d, op_in;
  logic [oal_pkg::FieldW-1:0]    key_q, key_d, dat_q, dat_d;
  logic [oal_pkg::IdxW-1:0]      at_q, at_d;
  logic [oal_pkg::CntW-1:0]      ptr_q, ptr_d, ptr_m1;
  logic                          rd_vld_q, rd_vld_d;
  logic [oal_pkg::IdxW-1:0]      rd_addr_q, rd_addr_d;
  logic [oal_pkg::CntW-1:0]      count_q, count_d, count_m1;
  logic                          done_q, done_d;
  logic                          success_q, success_d;
  logic [oal_pkg::FieldW-1:0]    rkey_q, rkey_d, rdat_q, rdat_d;

  logic                          dec_ok;
  logic [oal_pkg::IdxW-1:0]      dec_at;
  oal_pkg::state_e               dec_state;
  logic                          list_full, list_empty, pos_ok;

  logic                          ram_we, ram_re;
  logic [oal_pkg::IdxW-1:0]      ram_waddr, ram_raddr;
  logic [oal_pkg::WordW-1:0]     ram_wdata, ram_rdata;
  logic [oal_pkg::FieldW-1:0]    rd_key, rd_dat;
  logic                          hit;

  oal_ram #(
    .Width (oal_pkg::WordW),
    .Depth (oal_pkg::Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign op_in      = oal_pkg::opcode_e'(opcode_i);
  assign list_full  = (count_q == oal_pkg::CntW'(oal_pkg::Capacity));
  assign list_empty = (count_q == '0);
  assign pos_ok     = ({1'b0, position_i} < count_q);
  assign count_m1   = count_q - 1'b1;
  assign ptr_m1     = ptr_q - 1'b1;
  assign rd_key     = ram_rdata[oal_pkg::WordW-1:oal_pkg::FieldW];
  assign rd_dat     = ram_rdata[oal_pkg::FieldW-1:0];
  assign hit        = rd_vld_q && ((op_q == oal_pkg::OP_FIND_DATA) ? (rd_dat == dat_q)
                                                                  : (rd_key == key_q));

  // decode of a new item against the current count
  always_comb begin
    dec_ok    = 1'b0;
    dec_at    = '0;
    dec_state = oal_pkg::ST_IDLE;
    case (op_in)
      oal_pkg::OP_INS_FRONT: begin
        dec_ok    = !list_full;
        dec_state = oal_pkg::ST_INS;
      end
      oal_pkg::OP_INS_AT: begin
        dec_ok    = !list_full && pos_ok;
        dec_at    = position_i;
        dec_state = oal_pkg::ST_INS;
      end
      oal_pkg::OP_INS_BACK: begin
        dec_ok    = !list_full;
        dec_at    = count_q[oal_pkg::IdxW-1:0];
        dec_state = oal_pkg::ST_INS;
      end
      oal_pkg::OP_REM_FRONT: begin
        dec_ok    = !list_empty;
        dec_state = oal_pkg::ST_REM;
      end
      oal_pkg::OP_REM_AT: begin
        dec_ok    = pos_ok;
        dec_at    = position_i;
        dec_state = oal_pkg::ST_REM;
      end
      oal_pkg::OP_REM_BACK: begin
        dec_ok    = !list_empty;
        dec_at    = count_m1[oal_pkg::IdxW-1:0];
        dec_state = oal_pkg::ST_REM;
      end
      oal_pkg::OP_FIND_DATA, oal_pkg::OP_FIND_KEY: begin
        dec_ok    = !list_empty;
        dec_state = oal_pkg::ST_FIND;
      end
      default: begin
        dec_ok    = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    dat_d     = dat_q;
    at_d      = at_q;
    ptr_d     = ptr_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    count_d   = count_q;
    done_d    = 1'b0;
    success_d = success_q;
    rkey_d    = rkey_q;
    rdat_d    = rdat_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      oal_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d      = op_in;
          key_d     = entry_key_i;
          dat_d     = entry_data_i;
          at_d      = dec_at;
          success_d = 1'b0;
          rkey_d    = '0;
          rdat_d    = '0;
          if (dec_ok) begin
            state_d = dec_state;
            ptr_d   = (dec_state == oal_pkg::ST_INS) ? count_q : {1'b0, dec_at};
          end else begin
            done_d  = 1'b1;
          end
        end
      end

      // walk down from the top, each entry moves up one place
      oal_pkg::ST_INS: begin
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q + 1'b1;
          ram_wdata = ram_rdata;
        end
        if (ptr_q != {1'b0, at_q}) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_m1[oal_pkg::IdxW-1:0];
          ptr_d     = ptr_m1;
          rd_vld_d  = 1'b1;
          rd_addr_d = ptr_m1[oal_pkg::IdxW-1:0];
        end else if (!rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = at_q;
          ram_wdata = {key_q, dat_q};
          count_d   = count_q + 1'b1;
          success_d = 1'b1;
          done_d    = 1'b1;
          state_d   = oal_pkg::ST_IDLE;
        end
      end

      // first read returns the removed entry, later ones move down one place
      oal_pkg::ST_REM: begin
        if (rd_vld_q) begin
          if (rd_addr_q == at_q) begin
            rkey_d = rd_key;
            rdat_d = rd_dat;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_q - 1'b1;
            ram_wdata = ram_rdata;
          end
        end
        if (ptr_q != count_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[oal_pkg::IdxW-1:0];
          ptr_d     = ptr_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_addr_d = ptr_q[oal_pkg::IdxW-1:0];
        end else if (!rd_vld_q) begin
          count_d   = count_m1;
          success_d = 1'b1;
          done_d    = 1'b1;
          state_d   = oal_pkg::ST_IDLE;
        end
      end

      oal_pkg::ST_FIND: begin
        if (hit) begin
          rkey_d    = rd_key;
          rdat_d    = rd_dat;
          success_d = 1'b1;
          done_d    = 1'b1;
          state_d   = oal_pkg::ST_IDLE;
        end else if (ptr_q != count_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[oal_pkg::IdxW-1:0];
          ptr_d     = ptr_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_addr_d = ptr_q[oal_pkg::IdxW-1:0];
        end else if (!rd_vld_q) begin
          done_d    = 1'b1;
          state_d   = oal_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = oal_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= oal_pkg::ST_IDLE;
      rd_vld_q <= 1'b0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    dat_q     <= dat_d;
    at_q      <= at_d;
    ptr_q     <= ptr_d;
    rd_addr_q <= rd_addr_d;
    success_q <= success_d;
    rkey_q    <= rkey_d;
    rdat_q    <= rdat_d;
  end

  assign busy_o        = (state_q != oal_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign success_o     = success_q;
  assign result_key_o  = rkey_q;
  assign result_data_o = rdat_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = list_empty;
  assign is_full_o     = list_full;

endmodule

`default_nettype wire

FILE: design/oal_checker.sv
// port-level checks for the ordered array list engine, bound to the top level
`default_nettype none

module oal_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       done_o,
  input wire logic                       success_o,
  input wire logic [oal_pkg::FieldW-1:0] result_key_o,
  input wire logic [oal_pkg::FieldW-1:0] result_data_o,
  input wire logic [oal_pkg::CntW-1:0]   entry_count_o
);

  // an accepted item either starts work or is answered at once
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted item neither started nor answered");

  // the result cycle is also the first free cycle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  // failures carry no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (result_key_o == '0 && result_data_o == '0))
    else $error("failed item returned a nonzero entry");

  // the count only moves together with a result
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(entry_count_o))
    else $error("entry count changed without a result");

  // count never exceeds capacity, checked whenever a result is shown
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_count_o <= oal_pkg::CntW'(oal_pkg::Capacity)))
    else $error("entry count above capacity");

endmodule

bind ordered_array_list_engine oal_checker u_oal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .success_o     (success_o),
  .result_key_o  (result_key_o),
  .result_data_o (result_data_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire

FILE: bench/ordered_array_list_engine_tb.sv
// self-checking testbench for the ordered array list engine
`default_nettype none

module ordered_array_list_engine_tb;

  localparam int CycleLimit = 400000;
  localparam int MaxGap     = 20;
  localparam int DrainWait  = 2 * oal_pkg::Capacity + 8;
  localparam int PhaseItems = 550;

  typedef struct {
    logic                       ok;
    logic [oal_pkg::FieldW-1:0] key;
    logic [oal_pkg::FieldW-1:0] data;
    logic [oal_pkg::CntW-1:0]   cnt;
    logic                       empty;
    logic                       full;
  } list_result_t;

  // shadow copy of the list plus the queue of results still owed by the block
  class list_tracker;
    bit [oal_pkg::FieldW-1:0] keys [oal_pkg::Capacity];
    bit [oal_pkg::FieldW-1:0] vals [oal_pkg::Capacity];
    int              fill;
    list_result_t    owed [$];
    int              errors;
    int              checked;
    int              hits;
    int              times_full;
    int              times_empty;

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_request(oal_pkg::opcode_e op, logic [oal_pkg::IdxW-1:0] pos,
                               logic [oal_pkg::FieldW-1:0] k,
                               logic [oal_pkg::FieldW-1:0] d);
      list_result_t r;
      int           at;
      int           i;
      r = '{ok: 1'b0, key: '0, data: '0, cnt: '0, empty: 1'b0, full: 1'b0};
      at = 0;
      case (op)
        oal_pkg::OP_INS_FRONT, oal_pkg::OP_INS_AT, oal_pkg::OP_INS_BACK: begin
          if (fill < oal_pkg::Capacity) begin
            if (op == oal_pkg::OP_INS_FRONT) begin
              at = 0;
              r.ok = 1'b1;
            end else if (op == oal_pkg::OP_INS_AT) begin
              at = pos;
              r.ok = (int'(pos) < fill);
            end else begin
              at = fill;
              r.ok = 1'b1;
            end
            if (r.ok) begin
              for (i = fill; i > at; i--) begin
                keys[i] = keys[i-1];
                vals[i] = vals[i-1];
              end
              keys[at] = k;
              vals[at] = d;
              fill++;
            end
          end
        end
        oal_pkg::OP_REM_FRONT, oal_pkg::OP_REM_AT, oal_pkg::OP_REM_BACK: begin
          if (fill > 0) begin
            if (op == oal_pkg::OP_REM_FRONT) begin
              at = 0;
              r.ok = 1'b1;
            end else if (op == oal_pkg::OP_REM_AT) begin
              at = pos;
              r.ok = (int'(pos) < fill);
            end else begin
              at = fill - 1;
              r.ok = 1'b1;
            end
            if (r.ok) begin
              r.key  = keys[at];
              r.data = vals[at];
              for (i = at; i + 1 < fill; i++) begin
                keys[i] = keys[i+1];
                vals[i] = vals[i+1];
              end
              fill--;
            end
          end
        end
        default: begin
          // first match wins
          for (i = 0; i < fill && !r.ok; i++) begin
            if ((op == oal_pkg::OP_FIND_DATA) ? (vals[i] == d) : (keys[i] == k)) begin
              r.ok   = 1'b1;
              r.key  = keys[i];
              r.data = vals[i];
            end
          end
        end
      endcase
      r.cnt   = oal_pkg::CntW'(fill);
      r.empty = (fill == 0);
      r.full  = (fill == oal_pkg::Capacity);
      if (r.ok) hits++;
      if (r.full) times_full++;
      if (r.empty) times_empty++;
      owed.push_back(r);
    endfunction

    task check_result(list_result_t got);
      list_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = owed.pop_front();
        checked++;
        if (got.ok !== want.ok)
          report_mismatch($sformatf("success %b, want %b", got.ok, want.ok));
        if (got.key !== want.key)
          report_mismatch($sformatf("result_key %h, want %h", got.key, want.key));
        if (got.data !== want.data)
          report_mismatch($sformatf("result_data %h, want %h", got.data, want.data));
        if (got.cnt !== want.cnt)
          report_mismatch($sformatf("entry_count %0d, want %0d", got.cnt, want.cnt));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("is_empty %b, want %b", got.empty, want.empty));
        if (got.full !== want.full)
          report_mismatch($sformatf("is_full %b, want %b", got.full, want.full));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [oal_pkg::OpW-1:0]    opcode_i;
  logic [oal_pkg::IdxW-1:0]   position_i;
  logic [oal_pkg::FieldW-1:0] entry_key_i;
  logic [oal_pkg::FieldW-1:0] entry_data_i;
  logic                       done_o;
  logic                       success_o;
  logic [oal_pkg::FieldW-1:0] result_key_o;
  logic [oal_pkg::FieldW-1:0] result_data_o;
  logic [oal_pkg::CntW-1:0]   entry_count_o;
  logic                       is_empty_o;
  logic                       is_full_o;

  list_tracker tracker = new();
  int          items_sent;
  int          cycle_count;
  int          idle_pct;
  bit          growing;

  ordered_array_list_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .entry_key_i  (entry_key_i),
    .entry_data_i (entry_data_i),
    .done_o       (done_o),
    .success_o    (success_o),
    .result_key_o (result_key_o),
    .result_data_o(result_data_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results cannot be held off, so every strobe is taken at the edge ending it
  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.ok    = success_o;
      got.key   = result_key_o;
      got.data  = result_data_o;
      got.cnt   = entry_count_o;
      got.empty = is_empty_o;
      got.full  = is_full_o;
      tracker.check_result(got);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             tracker.owed.size());
    $display("Simulation FAILED");
    $finish;
  end

  // each cycle the sender stays idle with probability idle_pct
  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  function automatic logic [oal_pkg::FieldW-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 40) return oal_pkg::FieldW'($urandom_range(7));
    if (r < 45) return '1;
    if (r < 50) return '0;
    return oal_pkg::FieldW'($urandom());
  endfunction

  // holds start high until the item is taken; fields are noise while start is low
  task automatic send_item(oal_pkg::opcode_e op, logic [oal_pkg::IdxW-1:0] pos,
                           logic [oal_pkg::FieldW-1:0] k,
                           logic [oal_pkg::FieldW-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) begin
        opcode_i     <= oal_pkg::OpW'($urandom());
        position_i   <= oal_pkg::IdxW'($urandom());
        entry_key_i  <= $urandom();
        entry_data_i <= $urandom();
        @(posedge clk_i);
      end
    end
    start_i      <= 1'b1;
    opcode_i     <= op;
    position_i   <= pos;
    entry_key_i  <= k;
    entry_data_i <= d;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    tracker.note_request(op, pos, k, d);
    items_sent++;
  endtask

  task automatic send_random_item();
    oal_pkg::opcode_e           op;
    logic [oal_pkg::IdxW-1:0]   pos;
    logic [oal_pkg::FieldW-1:0] k;
    logic [oal_pkg::FieldW-1:0] d;
    int                         r;
    int                         idx;
    if (tracker.fill == oal_pkg::Capacity) growing = 1'b0;
    else if (tracker.fill == 0) growing = 1'b1;
    else if ($urandom_range(99) < 4) growing = ~growing;
    r = $urandom_range(99);
    if (r < 20) op = ($urandom_range(1)) ? oal_pkg::OP_FIND_DATA : oal_pkg::OP_FIND_KEY;
    else if ((r < 65) == growing) op = oal_pkg::opcode_e'($urandom_range(2));
    else op = oal_pkg::opcode_e'($urandom_range(5, 3));
    if (tracker.fill > 0 && $urandom_range(99) < 85)
      pos = oal_pkg::IdxW'($urandom_range(tracker.fill - 1));
    else
      pos = oal_pkg::IdxW'($urandom());
    k = pick_word();
    d = pick_word();
    // searches mostly look for something that is in the list
    if ((op == oal_pkg::OP_FIND_DATA || op == oal_pkg::OP_FIND_KEY) &&
        tracker.fill > 0 && $urandom_range(99) < 60) begin
      idx = $urandom_range(tracker.fill - 1);
      k = tracker.keys[idx];
      d = tracker.vals[idx];
    end
    send_item(op, pos, k, d);
  endtask

  initial begin
    int phase;
    int n;
    items_sent   = 0;
    idle_pct     = 0;
    growing      = 1'b1;
    rst_ni       = 1'b0;
    start_i      <= 1'b0;
    opcode_i     <= '0;
    position_i   <= '0;
    entry_key_i  <= '0;
    entry_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty list: removes, insert-at and search all fail; then inserts and searches
    send_item(oal_pkg::OP_REM_FRONT, '0, '0, '0);
    send_item(oal_pkg::OP_REM_AT, '1, '1, '1);
    send_item(oal_pkg::OP_INS_AT, '0, 32'h1234_5678, 32'h9abc_def0);
    send_item(oal_pkg::OP_FIND_KEY, '0, '0, '0);
    send_item(oal_pkg::OP_INS_BACK, '0, '0, '0);
    send_item(oal_pkg::OP_INS_FRONT, '0, '1, '1);
    send_item(oal_pkg::OP_INS_AT, 4'd1, 32'hdead_beef, 32'h0bad_f00d);
    send_item(oal_pkg::OP_FIND_DATA, '0, '1, '0);
    send_item(oal_pkg::OP_FIND_KEY, '0, 32'h5555_aaaa, '0);
    // fill up to capacity, then an insert on the full list and removes at the last index
    while (tracker.fill < oal_pkg::Capacity)
      send_item(oal_pkg::OP_INS_BACK, '0, $urandom(), $urandom());
    send_item(oal_pkg::OP_INS_FRONT, '0, '1, '1);
    send_item(oal_pkg::OP_REM_AT, '1, '0, '0);
    send_item(oal_pkg::OP_REM_AT, '1, '0, '0);
    send_item(oal_pkg::OP_REM_BACK, '0, '0, '0);

    // random part: no idling, heavy sender idling, light sender idling
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 80 : 24;
      for (n = 0; n < PhaseItems; n++) send_random_item();
    end
    start_i <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, %0d succeeded", items_sent,
             tracker.checked, tracker.hits);
    $display("list ended full %0d times and empty %0d times across three idle phases",
             tracker.times_full, tracker.times_empty);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.errors, tracker.owed.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/oal_pkg.sv
design/oal_ram.sv
design/ordered_array_list_engine.sv
design/oal_checker.sv
bench/ordered_array_list_engine_tb.sv
